FILE: src/mlpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types, constants and the default parameter table for the
// 1-16-16-1 Q24.8 perceptron.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  localparam int HID       = 16;
  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int HID_W     = $clog2(HID);
  localparam int TERM_W    = $clog2(HID + 1);

  // flat parameter layout
  localparam int OFS_W1      = 0;
  localparam int OFS_B1      = HID;
  localparam int OFS_W2      = 2 * HID;
  localparam int OFS_B2      = 2 * HID + HID * HID;
  localparam int OFS_W3      = 3 * HID + HID * HID;
  localparam int OFS_B3      = 4 * HID + HID * HID;
  localparam int PARAM_COUNT = 4 * HID + HID * HID + 1;
  localparam int ADDR_W      = $clog2(PARAM_COUNT);

  // reset values, Q24.8
  localparam logic [DATA_W-1:0] DEF_WEIGHT   = DATA_W'(25);
  localparam logic [DATA_W-1:0] DEF_BIAS     = DATA_W'(2);
  localparam logic [DATA_W-1:0] DEF_OUT_BIAS = DATA_W'(0);

  // item kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_INFER = 1'b1;

  typedef enum logic [1:0] {
    LAYER_1 = 2'd0,
    LAYER_2 = 2'd1,
    LAYER_3 = 2'd2
  } layer_t;

  // one step of the shared multiply-accumulate unit
  typedef struct packed {
    logic              valid;
    logic              bias;
    logic              first;
    layer_t            layer;
    logic [HID_W-1:0]  unit;
    logic [TERM_W-1:0] term;
  } mac_op_t;

  function automatic logic [DATA_W-1:0] param_default(input logic [ADDR_W-1:0] addr);
    logic [DATA_W-1:0] v;
    v = DEF_WEIGHT;
    if ((addr >= ADDR_W'(OFS_B1) && addr < ADDR_W'(OFS_W2)) ||
        (addr >= ADDR_W'(OFS_B2) && addr < ADDR_W'(OFS_W3))) begin
      v = DEF_BIAS;
    end else if (addr == ADDR_W'(OFS_B3)) begin
      v = DEF_OUT_BIAS;
    end
    return v;
  endfunction

endpackage

FILE: src/mlpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/mlpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_datapath
// Shared multiply-accumulate unit: operand select, multiply, accumulate, then
// scaling and bias add; ReLU into the hidden activation registers, none on pred.
// ----------------------------------------------------------------------------
module mlpq_datapath
  import mlpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mac_op_t           op,
  input  logic [DATA_W-1:0] sample,
  input  logic [DATA_W-1:0] rdata,
  output logic [DATA_W-1:0] pred,
  output logic              pred_valid
);

  localparam logic [DATA_W-1:0] RND = DATA_W'((1 << FRAC_BITS) - 1);

  logic [DATA_W-1:0] h1_r [HID];
  logic [DATA_W-1:0] h2_r [HID];

  mac_op_t           op1_r;
  mac_op_t           op2_r;
  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] a_nxt;
  logic [DATA_W-1:0] val2_r;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] acc_nxt;
  logic [DATA_W-1:0] adj;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] act;
  logic [DATA_W-1:0] pred_r;
  logic              pred_valid_r;

  // operand select at issue
  always_comb begin
    unique case (op.layer)
      LAYER_1: a_nxt = sample;
      LAYER_2: a_nxt = h1_r[op.term[HID_W-1:0]];
      LAYER_3: a_nxt = h2_r[op.term[HID_W-1:0]];
      default: a_nxt = '0;
    endcase
  end

  assign prod = DATA_W'(a_r * rdata);

  // accumulate, truncating scale toward zero, bias, relu
  always_comb begin
    acc_nxt = (op2_r.first ? '0 : acc_r) + val2_r;
    adj     = acc_r + (acc_r[DATA_W-1] ? RND : '0);
    quot    = DATA_W'($signed(adj) >>> FRAC_BITS);
    res     = quot + val2_r;
    act     = ($signed(res) > 0) ? res : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r        <= '0;
      op2_r        <= '0;
      pred_valid_r <= 1'b0;
    end else begin
      op1_r        <= op;
      op2_r        <= op1_r;
      pred_valid_r <= op2_r.valid && op2_r.bias && (op2_r.layer == LAYER_3);
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    val2_r <= op1_r.bias ? rdata : prod;
    if (op2_r.valid) begin
      if (!op2_r.bias) begin
        acc_r <= acc_nxt;
      end else begin
        unique case (op2_r.layer)
          LAYER_1: h1_r[op2_r.unit] <= act;
          LAYER_2: h2_r[op2_r.unit] <= act;
          LAYER_3: pred_r <= res;
          default: pred_r <= pred_r;
        endcase
      end
    end
  end

  assign pred       = pred_r;
  assign pred_valid = pred_valid_r;

endmodule

FILE: src/mlp_1x16x16x1_q8_8_infer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_1x16x16x1_q8_8_infer
// 1-16-16-1 perceptron in Q24.8, one shared multiply-accumulate unit
// stepped by a small sequencer over a single parameter RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_t*. in_tuser = 0 writes param_value at the flat
//   address param_index (beyond 320 the write is dropped) and gives no output
//   word. in_tuser = 1 runs one inference on sample and gives one
//   prediction on out_t*.
//   An inference issues one RAM read per cycle into the single multiplier:
//   16 x 2 + 16 x 17 + 17 = 321 steps. in_tready is low from acceptance
//   until the prediction is registered for out_t*; one item at a time.
//   The prediction sits in an output register, so write words and the next
//   inference are taken while it waits; a later prediction waits until
//   out_tready has taken the earlier one.
//   After reset a clearing pass loads the default parameters into every word
//   (weights 25, biases 2, output bias 0); in_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module mlp_1x16x16x1_q8_8_infer
  import mlpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // param_index[8:0], param_value[40:9], sample[72:41]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // prediction
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  layer_t            layer_r, layer_nxt;
  logic [HID_W-1:0]  unit_r, unit_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic              done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] sample_r;

  logic [ADDR_W-1:0] in_index;
  logic [DATA_W-1:0] in_value;
  logic [DATA_W-1:0] in_sample;
  logic              in_fire;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  mac_op_t           op;
  logic [TERM_W-1:0] n_terms;
  logic [HID_W-1:0]  last_unit;
  logic [DATA_W-1:0] pred;
  logic              pred_valid;
  logic              out_free;

  assign in_index  = in_tdata[ADDR_W-1:0];
  assign in_value  = in_tdata[ADDR_W+DATA_W-1:ADDR_W];
  assign in_sample = in_tdata[ADDR_W+2*DATA_W-1:ADDR_W+DATA_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // step descriptor for the shared unit
  always_comb begin
    n_terms   = (layer_r == LAYER_1) ? TERM_W'(1) : TERM_W'(HID);
    last_unit = (layer_r == LAYER_3) ? '0 : HID_W'(HID - 1);
    op        = '0;
    op.valid  = (state_r == ST_RUN);
    op.bias   = (term_r == n_terms);
    op.first  = (term_r == '0);
    op.layer  = layer_r;
    op.unit   = unit_r;
    op.term   = term_r;
    unique case (layer_r)
      LAYER_1: ram_raddr = op.bias ? ADDR_W'(OFS_B1) + ADDR_W'(unit_r)
                                   : ADDR_W'(OFS_W1) + ADDR_W'(unit_r);
      LAYER_2: ram_raddr = op.bias ? ADDR_W'(OFS_B2) + ADDR_W'(unit_r)
                                   : ADDR_W'(OFS_W2) + ADDR_W'(unit_r) * ADDR_W'(HID)
                                     + ADDR_W'(term_r);
      LAYER_3: ram_raddr = op.bias ? ADDR_W'(OFS_B3)
                                   : ADDR_W'(OFS_W3) + ADDR_W'(term_r);
      default: ram_raddr = '0;
    endcase
  end

  // ram write port: clearing pass or parameter word
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = param_default(clr_r);
    end else begin
      ram_we    = in_fire && (in_tuser == OP_WRITE) && (in_index < ADDR_W'(PARAM_COUNT));
      ram_waddr = in_index;
      ram_wdata = in_value;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    layer_nxt     = layer_r;
    unit_nxt      = unit_r;
    term_nxt      = term_r;
    done_nxt      = done_r || pred_valid;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(PARAM_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && in_tuser == OP_INFER) begin
          state_nxt = ST_RUN;
          layer_nxt = LAYER_1;
          unit_nxt  = '0;
          term_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (!op.bias) begin
          term_nxt = term_r + 1'b1;
        end else begin
          term_nxt = '0;
          if (unit_r == last_unit) begin
            unit_nxt = '0;
            unique case (layer_r)
              LAYER_1: layer_nxt = LAYER_2;
              LAYER_2: layer_nxt = LAYER_3;
              default: state_nxt = ST_WAIT;
            endcase
          end else begin
            unit_nxt = unit_r + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (done_r && out_free) begin
          done_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      layer_r     <= LAYER_1;
      unit_r      <= '0;
      term_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      layer_r     <= layer_nxt;
      unit_r      <= unit_nxt;
      term_r      <= term_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == OP_INFER) begin
      sample_r <= in_sample;
    end
    if (state_r == ST_WAIT && done_r && out_free) begin
      out_data_r <= pred;
    end
  end

  mlpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PARAM_COUNT)
  ) u_param_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mlpq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .sample     (sample_r),
    .rdata      (ram_rdata),
    .pred       (pred),
    .pred_valid (pred_valid)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sim/mlp_1x16x16x1_q8_8_infer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_1x16x16x1_q8_8_infer_test
// Self-checking bench for the 1-16-16-1 Q24.8 perceptron. Parameter writes and
// inferences are streamed in. A shadow copy of the parameter table predicts
// every prediction word, and each one is compared as it leaves the block.
// A directed set opens the run: default parameters, extreme samples, layout
// boundaries and dropped addresses. Random traffic follows, with random
// back-pressure and one long output hold-off.
// ----------------------------------------------------------------------------
module mlp_1x16x16x1_q8_8_infer_test
  import mlpq_pkg::*;
();

  localparam int CLK_HALF    = 2;
  localparam int RST_CYCLES  = 11;
  localparam int N_RANDOM    = 430;
  localparam int N_QUIET     = 50;
  localparam int LONG_HOLD   = 1500;
  localparam int DRAIN_WAIT  = 400;
  localparam int CYCLE_LIMIT = 600000;

  class mlp_tracker;
    int w1[HID];
    int b1[HID];
    int w2[HID*HID];
    int b2[HID];
    int w3[HID];
    int b3;
    logic [DATA_W-1:0] pending_predictions[$];
    int n_writes;
    int n_dropped;
    int n_infers;
    int n_checked;
    int n_errors;

    function new();
      for (int i = 0; i < HID; i++) begin
        w1[i] = DEF_WEIGHT;
        b1[i] = DEF_BIAS;
        b2[i] = DEF_BIAS;
        w3[i] = DEF_WEIGHT;
      end
      for (int i = 0; i < HID*HID; i++) begin
        w2[i] = DEF_WEIGHT;
      end
      b3 = DEF_OUT_BIAS;
    endfunction

    // truncating divide by the Q24.8 scale, then wrapping bias add
    function int rescale(int acc, int bias);
      return acc / (1 << FRAC_BITS) + bias;
    endfunction

    function int relu(int v);
      return (v > 0) ? v : 0;
    endfunction

    function void take_word(logic op, logic [8:0] idx, int val, int smp);
      int h1[HID];
      int h2[HID];
      int acc;
      int a;
      a = int'(idx);
      if (op == OP_WRITE) begin
        n_writes++;
        if (a < OFS_B1) begin
          w1[a] = val;
        end else if (a < OFS_W2) begin
          b1[a - OFS_B1] = val;
        end else if (a < OFS_B2) begin
          w2[a - OFS_W2] = val;
        end else if (a < OFS_W3) begin
          b2[a - OFS_B2] = val;
        end else if (a < OFS_B3) begin
          w3[a - OFS_W3] = val;
        end else if (a < PARAM_COUNT) begin
          b3 = val;
        end else begin
          n_dropped++;
        end
      end else begin
        n_infers++;
        for (int i = 0; i < HID; i++) begin
          h1[i] = relu(rescale(smp * w1[i], b1[i]));
        end
        for (int i = 0; i < HID; i++) begin
          acc = 0;
          for (int j = 0; j < HID; j++) begin
            acc += h1[j] * w2[i*HID + j];
          end
          h2[i] = relu(rescale(acc, b2[i]));
        end
        acc = 0;
        for (int i = 0; i < HID; i++) begin
          acc += h2[i] * w3[i];
        end
        pending_predictions.push_back(rescale(acc, b3));
      end
    endfunction

    function void check_prediction(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (pending_predictions.size() == 0) begin
        $error("prediction: none expected, got %0d", $signed(got));
        n_errors++;
        return;
      end
      want = pending_predictions.pop_front();
      n_checked++;
      if (got !== want) begin
        $error("prediction: expected %0d, got %0d", $signed(want), $signed(got));
        n_errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // param_index[8:0], param_value[40:9], sample[72:41]
  logic        in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // prediction

  mlp_tracker tracker = new();
  bit  quiet;
  bit  send_idle;
  bit  recv_idle;
  bit  hold_done;
  int  hold_cnt;
  int  stall_cnt;
  int  cycles;

  mlp_1x16x16x1_q8_8_infer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && tracker.n_infers + tracker.n_writes >= 60) begin
      hold_done  <= 1'b1;
      hold_cnt   <= LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt  <= stall_cnt - 1;
      out_tready <= 1'b0;
    end else if (!quiet && recv_idle && $urandom_range(0, 5) == 0) begin
      stall_cnt  <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) begin
        recv_idle <= ~recv_idle;
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_prediction(out_tdata);
    end
  end

  task automatic send_word(logic op, logic [8:0] idx, logic [31:0] val, logic [31:0] smp);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, smp, val, idx};
    do @(posedge clk); while (!in_tready);
    tracker.take_word(op, idx, val, smp);
    if (!quiet && send_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return -$urandom_range(1, 400);
      default: return $urandom_range(0, 200) - 40;
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return -$urandom_range(1, 3000);
      default: return $urandom_range(0, 2048) - 256;
    endcase
  endfunction

  function automatic logic [8:0] pick_index();
    if ($urandom_range(0, 11) == 0) begin
      return 9'($urandom_range(PARAM_COUNT, 511));
    end
    return 9'($urandom_range(0, PARAM_COUNT - 1));
  endfunction

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = OP_WRITE;
    in_tdata   = '0;
    quiet      = 1'b0;
    send_idle  = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, extreme samples, ignored fields
    send_word(OP_INFER, 9'd0, 32'd0, 32'd0);
    send_word(OP_INFER, 9'd0, 32'd0, 32'd256);
    send_word(OP_INFER, 9'd0, 32'd0, 32'h7fff_ffff);
    send_word(OP_INFER, 9'd0, 32'd0, 32'h8000_0000);
    send_word(OP_INFER, 9'd320, 32'hffff_ffff, -32'sd256);
    // layout boundaries and dropped addresses
    send_word(OP_WRITE, 9'd0, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_WRITE, 9'd320, 32'h7fff_ffff, 32'd0);
    send_word(OP_WRITE, 9'd321, 32'd0, 32'd0);
    send_word(OP_WRITE, 9'd511, 32'd0, 32'd0);
    send_word(OP_INFER, 9'd0, 32'd0, 32'd256);
    send_word(OP_WRITE, 9'd16, -32'sd1000, 32'd0);
    send_word(OP_WRITE, 9'd288, 32'h8000_0000, 32'd0);
    send_word(OP_WRITE, 9'd304, -32'sd25, 32'd0);
    send_word(OP_INFER, 9'd0, 32'd0, 32'd1000);
    send_word(OP_INFER, 9'd0, 32'd0, -32'sd1000);
    send_word(OP_WRITE, 9'd31, 32'hffff_ffff, 32'd0);
    send_word(OP_WRITE, 9'd32, 32'h7fff_ffff, 32'd0);
    send_word(OP_WRITE, 9'd287, -32'sd7, 32'd0);
    send_word(OP_WRITE, 9'd303, 32'd500, 32'd0);
    send_word(OP_WRITE, 9'd319, 32'd300, 32'd0);
    send_word(OP_INFER, 9'd0, 32'd0, 32'd12345);
    send_word(OP_INFER, 9'd0, 32'd0, -32'sd7);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) begin
        quiet <= 1'b1;
      end
      if ($urandom_range(0, 19) == 0) begin
        send_idle = ~send_idle;
      end
      if ($urandom_range(0, 4) < 3) begin
        send_word(OP_WRITE, pick_index(), pick_value(), $urandom);
      end else begin
        send_word(OP_INFER, 9'($urandom), $urandom, pick_sample());
      end
    end
    in_tvalid <= 1'b0;

    while (tracker.pending_predictions.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d parameter writes (%0d outside the layout) and %0d inferences",
             tracker.n_writes, tracker.n_dropped, tracker.n_infers);
    $display("%0d predictions checked, %0d mismatches", tracker.n_checked, tracker.n_errors);
    if (tracker.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/mlpq_pkg.sv
src/mlpq_ram.sv
src/mlpq_datapath.sv
src/mlp_1x16x16x1_q8_8_infer.sv
sim/mlp_1x16x16x1_q8_8_infer_test.sv
